FILE: rtl/core/led_color_frame_builder_crc8_top_macros.svh
// Assertion macros for the LED frame builder top level.
`ifndef LED_COLOR_FRAME_BUILDER_CRC8_TOP_MACROS_SVH
`define LED_COLOR_FRAME_BUILDER_CRC8_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCFB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCFB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lcfb_pkg.sv
`default_nettype none

package lcfb_pkg;

  localparam int MAX_LEDS = 15;
  localparam int LED_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int COLOR_W  = 3 * BYTE_W;

  localparam logic [BYTE_W-1:0] RGBF_PAD         = 8'hFF;
  localparam logic [BYTE_W-1:0] MIN_DIRECT_PROTO = 8'd4;
  localparam logic [BYTE_W-1:0] CRC_POLY         = 8'h07;

  typedef enum logic [1:0] {
    CFG_LED_TOTAL     = 2'd0,
    CFG_REVERSE_ORDER = 2'd1,
    CFG_DIRECT_SELECT = 2'd2,
    CFG_PROTO_VERSION = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [LED_W-1:0]  led_total;
    logic              reverse_order;
    logic              direct_select;
    logic [BYTE_W-1:0] proto_version;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [LED_W-1:0]   waddr;
    logic [COLOR_W-1:0] wdata;
    logic               re;
    logic [LED_W-1:0]   raddr;
  } ram_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_trailer;
    logic [BYTE_W-1:0] frame_crc;
    logic              refused;
    logic              last;
  } result_t;

  // CRC-8, polynomial 0x07, MSB first, one byte.
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lcfb_color_ram.sv
`default_nettype none

module lcfb_color_ram (
  input  wire logic                        clk,
  input  wire lcfb_pkg::ram_req_t          req,
  output logic [lcfb_pkg::COLOR_W-1:0]     rdata
);
  import lcfb_pkg::*;

  logic [COLOR_W-1:0] mem [MAX_LEDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/lcfb_frame_seq.sv
`default_nettype none

module lcfb_frame_seq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lcfb_pkg::cfg_t               cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [lcfb_pkg::COLOR_W-1:0] in_color,
  output lcfb_pkg::ram_req_t                ram_req,
  input  wire logic [lcfb_pkg::COLOR_W-1:0] ram_rdata,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output lcfb_pkg::result_t                 out_item
);
  import lcfb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_PRIME,
    S_HEAD,
    S_BYTES,
    S_TRAIL,
    S_REFUSE
  } state_t;

  state_t             state;
  logic [LED_W-1:0]   loaded_count;
  logic [BYTE_W-1:0]  crc_acc;
  logic [LED_W-1:0]   total_q;
  logic               rev_q;
  logic               direct_q;
  logic [LED_W-1:0]   rd_led;
  logic [LED_W-1:0]   emit_led;
  logic [1:0]         byte_sel;
  logic [COLOR_W-1:0] cur;

  logic [LED_W-1:0]   total_eff;
  logic [LED_W-1:0]   loaded_count_next;
  logic               accept;
  logic               complete;
  logic               refuse;
  logic               slot_free;
  logic               emitting;
  logic [BYTE_W-1:0]  color_byte;
  logic [BYTE_W-1:0]  emit_byte;
  logic [BYTE_W-1:0]  crc_next;
  logic [1:0]         last_sel;
  logic               led_done;
  logic               last_led;
  logic               more_to_read;

  always_comb begin
    if (cfg.led_total == '0) begin
      total_eff = LED_W'(1);
    end else if (cfg.led_total > LED_W'(MAX_LEDS)) begin
      total_eff = LED_W'(MAX_LEDS);
    end else begin
      total_eff = cfg.led_total;
    end
  end

  assign in_ready          = (state == S_IDLE);
  assign accept            = in_valid && in_ready;
  assign loaded_count_next = loaded_count + LED_W'(1);
  assign complete          = (loaded_count_next >= total_eff);
  assign refuse            = cfg.direct_select && (cfg.proto_version < MIN_DIRECT_PROTO);
  assign slot_free         = !out_valid || out_ready;
  // A new item enters the output register at this edge.
  assign emitting          = slot_free && ((state == S_HEAD) || (state == S_BYTES) ||
                                           (state == S_TRAIL) || (state == S_REFUSE));

  assign last_sel     = direct_q ? 2'd2 : 2'd3;
  assign led_done     = (byte_sel == last_sel);
  assign last_led     = (emit_led == total_q - LED_W'(1));
  assign more_to_read = (rd_led < total_q);

  always_comb begin
    case (byte_sel)
      2'd0:    color_byte = cur[23:16];
      2'd1:    color_byte = cur[15:8];
      2'd2:    color_byte = cur[7:0];
      default: color_byte = RGBF_PAD;
    endcase
  end

  assign emit_byte = (state == S_HEAD) ? BYTE_W'(total_q) : color_byte;
  assign crc_next  = crc8_byte(crc_acc, emit_byte);

  // The color memory is written only while loading and read only while a
  // frame goes out, so the two ports never touch the same entry at once.
  // One LED is read ahead of the one being sent.
  always_comb begin
    ram_req.we    = accept && (loaded_count < LED_W'(MAX_LEDS));
    ram_req.waddr = loaded_count;
    ram_req.wdata = in_color;
    ram_req.raddr = rev_q ? (total_q - LED_W'(1) - rd_led) : rd_led;
    case (state)
      S_FETCH: ram_req.re = 1'b1;
      S_PRIME: ram_req.re = more_to_read;
      S_BYTES: ram_req.re = slot_free && led_done && !last_led && more_to_read;
      default: ram_req.re = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded_count <= '0;
      crc_acc      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emitting) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (complete) begin
              loaded_count <= '0;
              crc_acc      <= '0;
              total_q      <= total_eff;
              rev_q        <= cfg.reverse_order;
              direct_q     <= cfg.direct_select;
              rd_led       <= '0;
              emit_led     <= '0;
              byte_sel     <= '0;
              state        <= refuse ? S_REFUSE : S_FETCH;
            end else begin
              loaded_count <= loaded_count_next;
            end
          end
        end
        S_FETCH: begin
          rd_led <= rd_led + LED_W'(1);
          state  <= S_PRIME;
        end
        S_PRIME: begin
          cur <= ram_rdata;
          if (more_to_read) begin
            rd_led <= rd_led + LED_W'(1);
          end
          state <= direct_q ? S_HEAD : S_BYTES;
        end
        S_HEAD: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_item  <= '{out_byte: emit_byte, is_trailer: 1'b0, frame_crc: '0,
                           refused: 1'b0, last: 1'b0};
            crc_acc   <= crc_next;
            state     <= S_BYTES;
          end
        end
        S_BYTES: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            crc_acc   <= crc_next;
            // In buffered mode the pad byte of the final LED closes the frame
            // and carries the checksum over everything sent.
            out_item  <= '{out_byte: emit_byte, is_trailer: 1'b0,
                           frame_crc: (led_done && last_led && !direct_q) ? crc_next : '0,
                           refused: 1'b0,
                           last: led_done && last_led && !direct_q};
            if (led_done) begin
              byte_sel <= '0;
              if (last_led) begin
                state <= direct_q ? S_TRAIL : S_IDLE;
              end else begin
                emit_led <= emit_led + LED_W'(1);
                cur      <= ram_rdata;
                if (more_to_read) begin
                  rd_led <= rd_led + LED_W'(1);
                end
              end
            end else begin
              byte_sel <= byte_sel + 2'd1;
            end
          end
        end
        S_TRAIL: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_item  <= '{out_byte: crc_acc, is_trailer: 1'b1, frame_crc: crc_acc,
                           refused: 1'b0, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        S_REFUSE: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_item  <= '{out_byte: '0, is_trailer: 1'b0, frame_crc: '0,
                           refused: 1'b1, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/led_color_frame_builder_crc8_top.sv
// LED frame builder with CRC-8. Each input item is one RGB color and is
// taken into a 15-entry color memory; items that do not complete the frame
// give no output. The item that completes the configured LED count starts
// the frame: after the FETCH and PRIME states prime the memory read, one
// byte leaves per cycle while the sink is ready, so a frame of N LEDs takes
// 4*N bytes in buffered mode (R,G,B,0xFF, checksum on the last byte) and
// 3*N+2 bytes in direct mode (count, R,G,B per LED, CRC trailer); the single
// byte-wide output sets that pace. A refused direct frame gives one flagged
// item. No new color is taken until the last byte of the frame sits in the
// output register.
`default_nettype none

`include "led_color_frame_builder_crc8_top_macros.svh"

module led_color_frame_builder_crc8_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // out_byte[7:0], frame_crc[15:8]
  output logic [1:0]       m_tuser,   // is_trailer[0], refused[1]
  output logic             m_tlast,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);
  import lcfb_pkg::*;

  cfg_t               cfg;
  ram_req_t           ram_req;
  logic [COLOR_W-1:0] ram_rdata;
  logic [COLOR_W-1:0] in_color;
  result_t            out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_total     <= LED_W'(12);
      cfg.reverse_order <= 1'b0;
      cfg.direct_select <= 1'b0;
      cfg.proto_version <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_LED_TOTAL:     cfg.led_total     <= cfg_wdata[LED_W-1:0];
        CFG_REVERSE_ORDER: cfg.reverse_order <= cfg_wdata[0];
        CFG_DIRECT_SELECT: cfg.direct_select <= cfg_wdata[0];
        CFG_PROTO_VERSION: cfg.proto_version <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Red is kept in the top byte so the memory word reads out in send order.
  assign in_color = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

  lcfb_color_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  lcfb_frame_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_color  (in_color),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = {out_item.frame_crc, out_item.out_byte};
  assign m_tuser = {out_item.refused, out_item.is_trailer};
  assign m_tlast = out_item.last;

  `LCFB_ASSERT_IMP(a_refused_alone, m_tvalid && m_tuser[1],
                   m_tlast && !m_tuser[0] && (m_tdata == '0),
                   "refused item must be a lone last item with no data")
  `LCFB_ASSERT_IMP(a_trailer_last, m_tvalid && m_tuser[0],
                   m_tlast && (m_tdata[7:0] == m_tdata[15:8]),
                   "trailer must close the frame and carry the checksum")
  `LCFB_ASSERT_IMP(a_crc_only_last, m_tvalid && !m_tlast,
                   (m_tdata[15:8] == '0) && (m_tuser == '0),
                   "checksum or flags seen before the end of a frame")
  `LCFB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
                   "output item changed while waiting for the sink")

endmodule

`default_nettype wire
